>>> rtl/b64sc_pkg.sv
// Shared types, character codes and alphabet functions for the base64 stream codec.
`timescale 1ns / 1ps

package b64sc_pkg;

   localparam int QDepth = 4;
   localparam int QAddrWidth = $clog2(QDepth);
   localparam int QCountWidth = $clog2(QDepth + 1);

   localparam logic ModeEncode = 1'b0;
   localparam logic ModeDecode = 1'b1;

   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5a;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7a;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;
   localparam logic [7:0] CharPlus = 8'h2b;
   localparam logic [7:0] CharSlash = 8'h2f;
   localparam logic [7:0] CharPad = 8'h3d;

   // One queued job: up to four result bytes, byte i at data[8*i +: 8].
   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  num;
      logic        last;
      logic        err;
   } job_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         sextet_to_char = CharUpperA + w;
      end else if (v < 6'd52) begin
         sextet_to_char = CharLowerA + w - 8'd26;
      end else if (v < 6'd62) begin
         sextet_to_char = CharZero + w - 8'd52;
      end else if (v == 6'd62) begin
         sextet_to_char = CharPlus;
      end else begin
         sextet_to_char = CharSlash;
      end
   endfunction

   // Returns {invalid, value}; the pad character gives value zero.
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         t = c - CharUpperA;
         char_to_sextet = {1'b0, t[5:0]};
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         t = c - CharLowerA + 8'd26;
         char_to_sextet = {1'b0, t[5:0]};
      end else if (c >= CharZero && c <= CharNine) begin
         t = c - CharZero + 8'd52;
         char_to_sextet = {1'b0, t[5:0]};
      end else if (c == CharPlus) begin
         char_to_sextet = {1'b0, 6'd62};
      end else if (c == CharSlash) begin
         char_to_sextet = {1'b0, 6'd63};
      end else if (c == CharPad) begin
         char_to_sextet = {1'b0, 6'd0};
      end else begin
         char_to_sextet = {1'b1, 6'd63};
      end
   endfunction

endpackage

>>> rtl/b64sc_front.sv
// Front end: accepts items, builds groups and posts finished groups as jobs.
`timescale 1ns / 1ps

module b64sc_front import b64sc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_mode,
   input  logic          req_valid,
   input  logic [7:0]    req_in_byte,
   input  logic          req_in_last,
   input  logic          queue_full,
   output logic          accept,
   output logic          push,
   output job_type       push_job
);

   logic        mode_ff, mode_in;
   logic [23:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic [1:0]  pad_count_ff, pad_count_in;
   logic        error_seen_ff, error_seen_in;

   logic [2:0]  cnt;
   logic [23:0] enc_bits;
   logic [23:0] enc_word;
   logic [2:0]  enc_chars;
   logic [6:0]  dec_code;
   logic [23:0] dec_bits;
   logic [1:0]  dec_pad;
   logic        dec_err;

   assign accept = req_valid && !queue_full;
   assign cnt = {1'b0, group_count_ff} + 3'd1;
   assign enc_bits = {group_bits_ff[15:0], req_in_byte};
   assign dec_code = char_to_sextet(req_in_byte);
   assign dec_bits = {group_bits_ff[17:0], dec_code[5:0]};
   assign dec_err = error_seen_ff || dec_code[6];

   always_comb begin
      unique case (cnt)
         3'd1: begin
            enc_word = {enc_bits[7:0], 16'd0};
            enc_chars = 3'd2;
         end
         3'd2: begin
            enc_word = {enc_bits[15:0], 8'd0};
            enc_chars = 3'd3;
         end
         default: begin
            enc_word = enc_bits;
            enc_chars = 3'd4;
         end
      endcase
      if (req_in_byte == CharPad) begin
         dec_pad = (pad_count_ff == 2'd2) ? 2'd2 : pad_count_ff + 2'd1;
      end else begin
         dec_pad = 2'd0;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      group_bits_in = group_bits_ff;
      group_count_in = group_count_ff;
      pad_count_in = pad_count_ff;
      error_seen_in = error_seen_ff;
      push = 1'b0;
      push_job = '0;
      if (csr_write_enable) begin
         mode_in = csr_mode;
         group_bits_in = '0;
         group_count_in = '0;
         pad_count_in = '0;
         error_seen_in = 1'b0;
      end else if (accept) begin
         if (mode_ff == ModeEncode) begin
            if (cnt == 3'd3 || req_in_last) begin
               push = 1'b1;
               for (int i = 0; i < 4; i++) begin
                  push_job.data[8*i +: 8] = (3'(i) < enc_chars) ?
                     sextet_to_char(enc_word[18 - 6*i +: 6]) : CharPad;
               end
               push_job.num = 3'd4;
               push_job.last = req_in_last;
               push_job.err = 1'b0;
               group_bits_in = '0;
               group_count_in = '0;
               pad_count_in = '0;
               error_seen_in = 1'b0;
            end else begin
               group_bits_in = enc_bits;
               group_count_in = cnt[1:0];
            end
         end else begin
            if (cnt == 3'd4) begin
               push = 1'b1;
               push_job.data = {8'd0, dec_bits[7:0], dec_bits[15:8], dec_bits[23:16]};
               push_job.num = req_in_last ? 3'd3 - {1'b0, dec_pad} : 3'd3;
               push_job.last = req_in_last;
               push_job.err = req_in_last && dec_err;
               group_bits_in = '0;
               group_count_in = '0;
               pad_count_in = '0;
               error_seen_in = req_in_last ? 1'b0 : dec_err;
            end else if (req_in_last) begin
               push = 1'b1;
               push_job.data = '0;
               push_job.num = 3'd1;
               push_job.last = 1'b1;
               push_job.err = 1'b1;
               group_bits_in = '0;
               group_count_in = '0;
               pad_count_in = '0;
               error_seen_in = 1'b0;
            end else begin
               group_bits_in = dec_bits;
               group_count_in = cnt[1:0];
               pad_count_in = dec_pad;
               error_seen_in = dec_err;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeEncode;
         group_bits_ff <= '0;
         group_count_ff <= '0;
         pad_count_ff <= '0;
         error_seen_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         group_bits_ff <= group_bits_in;
         group_count_ff <= group_count_in;
         pad_count_ff <= pad_count_in;
         error_seen_ff <= error_seen_in;
      end
   end

endmodule

>>> rtl/b64sc_queue.sv
// Short job queue between the front end and the result back end.
`timescale 1ns / 1ps

module b64sc_queue import b64sc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   job_type                 slots_ff [QDepth];
   logic [QAddrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAddrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCountWidth-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == QCountWidth'(QDepth));
   assign head_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAddrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAddrWidth'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/b64sc_back.sv
// Back end: walks the head job and drives one result item per cycle into the output register unless rsp_stall holds it.
`timescale 1ns / 1ps

module b64sc_back import b64sc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_error
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       error_ff, error_in;
   logic       load;
   logic       at_end;

   assign load = !empty && (!valid_ff || !rsp_stall);
   assign at_end = ({1'b0, idx_ff} + 3'd1) == head_job.num;
   assign pop = load && at_end;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      error_in = error_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in = head_job.data[8*idx_ff +: 8];
         last_in = head_job.last && at_end;
         error_in = head_job.err && at_end;
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      error_ff <= error_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;
   assign rsp_error = error_ff;

endmodule

>>> rtl/base64_stream_codec.sv
// Top level of the streaming base64 encoder and decoder.
`timescale 1ns / 1ps

// The block takes one item per cycle on the req_ channel as long as its four-entry job queue has
// room, and delivers one result item per cycle on the rsp_ channel from a registered output while
// rsp_stall is low. Encoding turns every three bytes into four characters, so a steady byte stream
// is held back by the output stage; decoding turns four characters into three bytes and runs at
// the input rate. In encode mode the output stage, which emits one item per cycle, sets the
// sustained rate. The first result of a group is written into the job queue, then the output register.
// Write csr_mode only while the block is idle; a write also discards any partial group and the
// error flag. In decode mode rsp_error is valid on the item marked last.

module base64_stream_codec import b64sc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_mode,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_error
);

   logic    accept;
   logic    push;
   job_type push_job;
   logic    pop;
   job_type head_job;
   logic    empty;
   logic    full;

   assign req_stall = full;

   b64sc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_mode         (csr_mode),
      .req_valid        (req_valid),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .queue_full       (full),
      .accept           (accept),
      .push             (push),
      .push_job         (push_job)
   );

   b64sc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push && accept),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (empty),
      .full     (full)
   );

   b64sc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .empty        (empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_error    (rsp_error)
   );

endmodule
